// File: design/sce_pkg.sv
// ----------------------------------------------------------------------------
// sce_pkg: shared types, constants and saturation helpers
// Fixed-point widths, register indexes, segment codes and the switch-point
// record used by the S-curve evaluator and its pipeline.
// ----------------------------------------------------------------------------
package sce_pkg;

  localparam int DATA_W        = 32;
  localparam int MAG_W         = 62;               // magnitudes up to 2^61
  localparam int WIDE_W        = 64;               // signed intermediates
  localparam int PROD_W        = DATA_W + MAG_W;   // 32 x 62 product
  localparam int PP_HI_W       = MAG_W;            // 30 x 32 partial
  localparam int NUM_POINTS    = 8;
  localparam int PT_IDX_W      = $clog2(NUM_POINTS);
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [MAG_W-1:0]         WSAT_MAG = 62'h2000_0000_0000_0000;
  localparam logic signed [WIDE_W-1:0] WSAT     = 64'sh2000_0000_0000_0000;
  localparam logic signed [WIDE_W-1:0] U32_MAX  = 64'sh0000_0000_FFFF_FFFF;
  localparam logic signed [WIDE_W-1:0] S32_MAX  = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] S32_MIN  = -64'sh0000_0000_8000_0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_JERK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JDUR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ADUR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CDUR   = 3'd5;

  // segment codes (segment i runs from point i-1 to point i)
  localparam logic [PT_IDX_W-1:0] SEG_JERK_IN   = 3'd1;
  localparam logic [PT_IDX_W-1:0] SEG_ACCEL     = 3'd2;
  localparam logic [PT_IDX_W-1:0] SEG_JERK_OUT  = 3'd3;
  localparam logic [PT_IDX_W-1:0] SEG_CRUISE    = 3'd4;
  localparam logic [PT_IDX_W-1:0] SEG_DECEL_IN  = 3'd5;
  localparam logic [PT_IDX_W-1:0] SEG_DECEL     = 3'd6;
  localparam logic [PT_IDX_W-1:0] SEG_DECEL_OUT = 3'd7;

  typedef struct packed {
    logic                rb;    // table rebuild item, not a query
    logic                pass;  // query clamped to an end point
    logic [PT_IDX_W-1:0] seg;
  } ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0]        tm;
    logic [DATA_W-1:0]        pos;
    logic [DATA_W-1:0]        vel;
    logic signed [DATA_W-1:0] acc;
  } point_t;

  typedef struct packed {
    logic                     vld;
    logic [PT_IDX_W-1:0]      seg;
    logic [DATA_W-1:0]        pos;
    logic [DATA_W-1:0]        vel;
    logic signed [DATA_W-1:0] acc;
  } wb_t;

  function automatic logic signed [WIDE_W-1:0] sat_w(input logic signed [WIDE_W-1:0] x);
    if (x > WSAT) sat_w = WSAT;
    else if (x < -WSAT) sat_w = -WSAT;
    else sat_w = x;
  endfunction

  function automatic logic [DATA_W-1:0] sat_u32(input logic signed [WIDE_W-1:0] x);
    if (x < 0) sat_u32 = '0;
    else if (x > U32_MAX) sat_u32 = '1;
    else sat_u32 = x[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [WIDE_W-1:0] x);
    if (x > S32_MAX) sat_s32 = S32_MAX[DATA_W-1:0];
    else if (x < S32_MIN) sat_s32 = S32_MIN[DATA_W-1:0];
    else sat_s32 = x[DATA_W-1:0];
  endfunction

  function automatic logic signed [WIDE_W-1:0] sgn64(input logic neg,
                                                     input logic [MAG_W-1:0] mag);
    logic signed [WIDE_W-1:0] m;
    m = $signed({2'b00, mag});
    sgn64 = neg ? -m : m;
  endfunction

endpackage

// File: design/sce_pipe.sv
// ----------------------------------------------------------------------------
// sce_pipe: twelve-stage segment evaluation pipeline
// Locates the segment of a query (or takes a forced one for a table rebuild),
// then evaluates the constant-jerk cubic with split 32-bit multiplies.
// ----------------------------------------------------------------------------
module sce_pipe import sce_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              flush,
  input  logic              in_vld,
  output logic              in_rdy,
  input  ctl_t              in_ctl,
  input  logic [DATA_W-1:0] in_val,
  input  point_t            tbl [NUM_POINTS],
  input  logic [DATA_W-1:0] jerk_lim,
  input  logic [DATA_W-1:0] accel_lim,
  input  logic [DATA_W-1:0] vel_lim,
  output logic              out_vld,
  input  logic              out_rdy,
  output logic [DATA_W-1:0] out_pos,
  output logic [DATA_W-1:0] out_vel,
  output wb_t               wb
);

  localparam int NS = 12;
  localparam logic [DATA_W-1:0] RECIP3 = 32'hAAAA_AAAB;
  localparam logic [DATA_W-1:0] RHK1   = 32'h5555_5555;
  localparam logic [DATA_W-1:0] RHK2   = 32'hAAAA_AAAA;
  localparam logic [1:0]        REM1   = 2'd1;
  localparam logic [1:0]        REM2   = 2'd2;

  function automatic logic [MAG_W-1:0] q_scale(input logic [PROD_W-1:0] raw);
    logic [PROD_W-1:0] s;
    s = raw >> FRAC_BITS;
    if (s > PROD_W'(WSAT_MAG)) q_scale = WSAT_MAG;
    else q_scale = s[MAG_W-1:0];
  endfunction

  function automatic logic [PROD_W-1:0] join_pp(input logic [2*DATA_W-1:0] lo,
                                                input logic [PP_HI_W-1:0] hi);
    join_pp = PROD_W'(lo) + (PROD_W'(hi) << DATA_W);
  endfunction

  // stall control: a stage loads when it or any later stage has room
  logic [NS-1:0] v_r;
  logic [NS-1:0] go;
  logic          last_go;

  ctl_t s12_ctl_r;

  assign last_go = ~v_r[NS-1] | s12_ctl_r.rb | out_rdy;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      go[k] = last_go | (|(~v_r & ({NS{1'b1}} << k)));
    end
  end

  assign in_rdy = go[0];

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      v_r <= '0;
    end else begin
      if (go[0]) v_r[0] <= in_vld;
      for (int k = 1; k < NS; k++) begin
        if (go[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage 1: capture
  ctl_t              s1_ctl_r;
  logic [DATA_W-1:0] s1_val_r;

  always_ff @(posedge clk) begin
    if (go[0]) begin
      s1_ctl_r <= in_ctl;
      s1_val_r <= in_val;
    end
  end

  // stage 2: segment search
  ctl_t                s2_ctl_r;
  logic [DATA_W-1:0]   s2_val_r;
  logic [PT_IDX_W-1:0] s2_bidx_r;
  ctl_t                c2;
  logic [PT_IDX_W-1:0] bidx2;
  logic                lo2, hi2;
  logic [PT_IDX_W-1:0] segq2;

  always_comb begin
    lo2   = s1_val_r <= tbl[0].tm;
    hi2   = s1_val_r > tbl[NUM_POINTS-1].tm;
    segq2 = SEG_DECEL_OUT;
    for (int i = NUM_POINTS - 1; i >= 1; i--) begin
      if (s1_val_r <= tbl[i].tm) segq2 = PT_IDX_W'(i);
    end
    c2 = s1_ctl_r;
    if (s1_ctl_r.rb) begin
      c2.pass = 1'b0;
      bidx2   = s1_ctl_r.seg - 1'b1;
    end else begin
      c2.pass = lo2 | hi2;
      c2.seg  = segq2;
      if (lo2) bidx2 = '0;
      else if (hi2) bidx2 = PT_IDX_W'(NUM_POINTS - 1);
      else bidx2 = segq2 - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go[1]) begin
      s2_ctl_r  <= c2;
      s2_val_r  <= s1_val_r;
      s2_bidx_r <= bidx2;
    end
  end

  // stage 3: base point and operands
  ctl_t                     s3_ctl_r;
  logic [DATA_W-1:0]        s3_dt_r, s3_jmag_r, s3_a0mag_r, s3_v0_r, s3_p0_r;
  logic                     s3_jneg_r;
  logic signed [DATA_W-1:0] s3_a0_r;
  point_t                   base3;
  logic                     jon3, jneg3;

  always_comb begin
    base3 = tbl[s2_bidx_r];
    jon3  = 1'b0;
    jneg3 = 1'b0;
    unique case (s2_ctl_r.seg)
      SEG_JERK_IN, SEG_DECEL_OUT: jon3 = 1'b1;
      SEG_JERK_OUT, SEG_DECEL_IN: begin
        jon3  = 1'b1;
        jneg3 = 1'b1;
      end
      default: jon3 = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (go[2]) begin
      s3_ctl_r   <= s2_ctl_r;
      s3_dt_r    <= s2_ctl_r.rb ? s2_val_r : s2_val_r - base3.tm;
      s3_jmag_r  <= (jon3 && !s2_ctl_r.pass) ? jerk_lim : '0;
      s3_jneg_r  <= jneg3;
      s3_a0_r    <= base3.acc;
      s3_a0mag_r <= base3.acc[DATA_W-1] ? DATA_W'(-base3.acc) : DATA_W'(base3.acc);
      s3_v0_r    <= base3.vel;
      s3_p0_r    <= base3.pos;
    end
  end

  // stage 4: first products
  ctl_t                     s4_ctl_r;
  logic [2*DATA_W-1:0]      s4_tt_r, s4_jd_r, s4_ad_r, s4_vd_r;
  logic [DATA_W-1:0]        s4_dt_r, s4_jmag_r, s4_a0mag_r, s4_v0_r, s4_p0_r;
  logic                     s4_jneg_r;
  logic signed [DATA_W-1:0] s4_a0_r;

  always_ff @(posedge clk) begin
    if (go[3]) begin
      s4_ctl_r   <= s3_ctl_r;
      s4_tt_r    <= s3_dt_r * s3_dt_r;
      s4_jd_r    <= s3_jmag_r * s3_dt_r;
      s4_ad_r    <= s3_a0mag_r * s3_dt_r;
      s4_vd_r    <= s3_v0_r * s3_dt_r;
      s4_dt_r    <= s3_dt_r;
      s4_jmag_r  <= s3_jmag_r;
      s4_a0mag_r <= s3_a0mag_r;
      s4_v0_r    <= s3_v0_r;
      s4_p0_r    <= s3_p0_r;
      s4_jneg_r  <= s3_jneg_r;
      s4_a0_r    <= s3_a0_r;
    end
  end

  // stage 5: scale
  ctl_t                     s5_ctl_r;
  logic [MAG_W-1:0]         s5_t2_r, s5_jdt_r, s5_adt_r, s5_vdt_r;
  logic [DATA_W-1:0]        s5_dt_r, s5_jmag_r, s5_a0mag_r, s5_v0_r, s5_p0_r;
  logic                     s5_jneg_r;
  logic signed [DATA_W-1:0] s5_a0_r;

  always_ff @(posedge clk) begin
    if (go[4]) begin
      s5_ctl_r   <= s4_ctl_r;
      s5_t2_r    <= q_scale(PROD_W'(s4_tt_r));
      s5_jdt_r   <= q_scale(PROD_W'(s4_jd_r));
      s5_adt_r   <= q_scale(PROD_W'(s4_ad_r));
      s5_vdt_r   <= q_scale(PROD_W'(s4_vd_r));
      s5_dt_r    <= s4_dt_r;
      s5_jmag_r  <= s4_jmag_r;
      s5_a0mag_r <= s4_a0mag_r;
      s5_v0_r    <= s4_v0_r;
      s5_p0_r    <= s4_p0_r;
      s5_jneg_r  <= s4_jneg_r;
      s5_a0_r    <= s4_a0_r;
    end
  end

  // stage 6: partial products of t2, first sums
  ctl_t                     s6_ctl_r;
  logic [2*DATA_W-1:0]      s6_tdlo_r, s6_jtlo_r, s6_atlo_r;
  logic [PP_HI_W-1:0]       s6_tdhi_r, s6_jthi_r, s6_athi_r;
  logic [DATA_W-1:0]        s6_jmag_r, s6_v0_r, s6_p0_r;
  logic                     s6_jneg_r, s6_a0neg_r;
  logic signed [WIDE_W-1:0] s6_aw_r, s6_vpart_r, s6_ppart_r;

  always_ff @(posedge clk) begin
    if (go[5]) begin
      s6_ctl_r   <= s5_ctl_r;
      s6_tdlo_r  <= s5_t2_r[DATA_W-1:0] * s5_dt_r;
      s6_tdhi_r  <= s5_t2_r[MAG_W-1:DATA_W] * s5_dt_r;
      s6_jtlo_r  <= s5_t2_r[DATA_W-1:0] * s5_jmag_r;
      s6_jthi_r  <= s5_t2_r[MAG_W-1:DATA_W] * s5_jmag_r;
      s6_atlo_r  <= s5_t2_r[DATA_W-1:0] * s5_a0mag_r;
      s6_athi_r  <= s5_t2_r[MAG_W-1:DATA_W] * s5_a0mag_r;
      s6_aw_r    <= sat_w(WIDE_W'(s5_a0_r) + sgn64(s5_jneg_r, s5_jdt_r));
      s6_vpart_r <= sat_w($signed({32'b0, s5_v0_r}) + sgn64(s5_a0_r[DATA_W-1], s5_adt_r));
      s6_ppart_r <= sat_w($signed({32'b0, s5_p0_r}) + sgn64(1'b0, s5_vdt_r));
      s6_jmag_r  <= s5_jmag_r;
      s6_v0_r    <= s5_v0_r;
      s6_p0_r    <= s5_p0_r;
      s6_jneg_r  <= s5_jneg_r;
      s6_a0neg_r <= s5_a0_r[DATA_W-1];
    end
  end

  // stage 7: t3, j*t2, a0*t2
  ctl_t                     s7_ctl_r;
  logic [MAG_W-1:0]         s7_t3_r, s7_jt2_r, s7_at2_r;
  logic [DATA_W-1:0]        s7_jmag_r, s7_v0_r, s7_p0_r;
  logic                     s7_jneg_r, s7_a0neg_r;
  logic signed [WIDE_W-1:0] s7_aw_r, s7_vpart_r, s7_ppart_r;

  always_ff @(posedge clk) begin
    if (go[6]) begin
      s7_ctl_r   <= s6_ctl_r;
      s7_t3_r    <= q_scale(join_pp(s6_tdlo_r, s6_tdhi_r));
      s7_jt2_r   <= q_scale(join_pp(s6_jtlo_r, s6_jthi_r));
      s7_at2_r   <= q_scale(join_pp(s6_atlo_r, s6_athi_r));
      s7_jmag_r  <= s6_jmag_r;
      s7_v0_r    <= s6_v0_r;
      s7_p0_r    <= s6_p0_r;
      s7_jneg_r  <= s6_jneg_r;
      s7_a0neg_r <= s6_a0neg_r;
      s7_aw_r    <= s6_aw_r;
      s7_vpart_r <= s6_vpart_r;
      s7_ppart_r <= s6_ppart_r;
    end
  end

  // stage 8: j*t3 partials, velocity done, a0*t2/2
  ctl_t                     s8_ctl_r;
  logic [2*DATA_W-1:0]      s8_j3lo_r;
  logic [PP_HI_W-1:0]       s8_j3hi_r;
  logic [DATA_W-1:0]        s8_v0_r, s8_p0_r;
  logic                     s8_jneg_r;
  logic signed [WIDE_W-1:0] s8_aw_r, s8_vfin_r, s8_ppart_r, s8_at2h_r;

  always_ff @(posedge clk) begin
    if (go[7]) begin
      s8_ctl_r   <= s7_ctl_r;
      s8_j3lo_r  <= s7_t3_r[DATA_W-1:0] * s7_jmag_r;
      s8_j3hi_r  <= s7_t3_r[MAG_W-1:DATA_W] * s7_jmag_r;
      s8_vfin_r  <= sat_w(s7_vpart_r + sgn64(s7_jneg_r, {1'b0, s7_jt2_r[MAG_W-1:1]}));
      s8_at2h_r  <= sgn64(s7_a0neg_r, {1'b0, s7_at2_r[MAG_W-1:1]});
      s8_v0_r    <= s7_v0_r;
      s8_p0_r    <= s7_p0_r;
      s8_jneg_r  <= s7_jneg_r;
      s8_aw_r    <= s7_aw_r;
      s8_ppart_r <= s7_ppart_r;
    end
  end

  // stage 9: j*t3
  ctl_t                     s9_ctl_r;
  logic [MAG_W-1:0]         s9_jt3_r;
  logic [DATA_W-1:0]        s9_v0_r, s9_p0_r;
  logic                     s9_jneg_r;
  logic signed [WIDE_W-1:0] s9_aw_r, s9_vfin_r, s9_ppart_r, s9_at2h_r;

  always_ff @(posedge clk) begin
    if (go[8]) begin
      s9_ctl_r   <= s8_ctl_r;
      s9_jt3_r   <= q_scale(join_pp(s8_j3lo_r, s8_j3hi_r));
      s9_v0_r    <= s8_v0_r;
      s9_p0_r    <= s8_p0_r;
      s9_jneg_r  <= s8_jneg_r;
      s9_aw_r    <= s8_aw_r;
      s9_vfin_r  <= s8_vfin_r;
      s9_ppart_r <= s8_ppart_r;
      s9_at2h_r  <= s8_at2h_r;
    end
  end

  // stage 10: divide by 6, upper word: (jt3/2) high part over 3
  ctl_t                     s10_ctl_r;
  logic [27:0]              s10_qh_r;
  logic [1:0]               s10_rh_r;
  logic [DATA_W-1:0]        s10_ml_r, s10_v0_r, s10_p0_r;
  logic                     s10_jneg_r;
  logic signed [WIDE_W-1:0] s10_aw_r, s10_vfin_r, s10_ppart_r, s10_at2h_r;
  logic [28:0]              mh10, three_q10;
  logic [60:0]              ph10;
  logic [27:0]              qh10;

  always_comb begin
    mh10      = s9_jt3_r[MAG_W-1:33];
    ph10      = mh10 * RECIP3;
    qh10      = ph10[60:33];
    three_q10 = {qh10, 1'b0} + {1'b0, qh10};
  end

  always_ff @(posedge clk) begin
    if (go[9]) begin
      s10_ctl_r   <= s9_ctl_r;
      s10_qh_r    <= qh10;
      s10_rh_r    <= 2'(mh10 - three_q10);
      s10_ml_r    <= s9_jt3_r[32:1];
      s10_v0_r    <= s9_v0_r;
      s10_p0_r    <= s9_p0_r;
      s10_jneg_r  <= s9_jneg_r;
      s10_aw_r    <= s9_aw_r;
      s10_vfin_r  <= s9_vfin_r;
      s10_ppart_r <= s9_ppart_r;
      s10_at2h_r  <= s9_at2h_r;
    end
  end

  // stage 11: divide by 6, lower word
  ctl_t                     s11_ctl_r;
  logic [60:0]              s11_j6_r;
  logic [DATA_W-1:0]        s11_v0_r, s11_p0_r;
  logic                     s11_jneg_r;
  logic signed [WIDE_W-1:0] s11_aw_r, s11_vfin_r, s11_ppart_r, s11_at2h_r;
  logic [DATA_W:0]          n11;
  logic [64:0]              pn11;
  logic [DATA_W-1:0]        rhk11;

  always_comb begin
    n11  = {1'b0, s10_ml_r} + 33'(s10_rh_r);
    pn11 = n11 * RECIP3;
    unique case (s10_rh_r)
      REM1:    rhk11 = RHK1;
      REM2:    rhk11 = RHK2;
      default: rhk11 = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (go[10]) begin
      s11_ctl_r   <= s10_ctl_r;
      s11_j6_r    <= 61'({s10_qh_r, 32'b0}) + 61'(rhk11) + 61'(pn11[64:33]);
      s11_v0_r    <= s10_v0_r;
      s11_p0_r    <= s10_p0_r;
      s11_jneg_r  <= s10_jneg_r;
      s11_aw_r    <= s10_aw_r;
      s11_vfin_r  <= s10_vfin_r;
      s11_ppart_r <= s10_ppart_r;
      s11_at2h_r  <= s10_at2h_r;
    end
  end

  // stage 12: final sums, overrides, clamps (output register)
  logic [DATA_W-1:0]        s12_pos_r, s12_vel_r;
  logic signed [DATA_W-1:0] s12_acc_r;
  logic signed [WIDE_W-1:0] pt12, p12, a12;
  logic [DATA_W-1:0]        pos12, vel12;

  always_comb begin
    pt12 = sat_w(s11_at2h_r + sgn64(s11_jneg_r, MAG_W'(s11_j6_r)));
    p12  = sat_w(s11_ppart_r + pt12);
    unique case (s11_ctl_r.seg)
      SEG_ACCEL:  a12 = $signed({32'b0, accel_lim});
      SEG_DECEL:  a12 = -$signed({32'b0, accel_lim});
      SEG_CRUISE: a12 = '0;
      default:    a12 = s11_aw_r;
    endcase
    if (s11_ctl_r.pass) begin
      pos12 = s11_p0_r;
      vel12 = s11_v0_r;
    end else begin
      pos12 = sat_u32(p12);
      vel12 = (s11_ctl_r.seg == SEG_CRUISE) ? vel_lim : sat_u32(s11_vfin_r);
    end
  end

  always_ff @(posedge clk) begin
    if (go[11]) begin
      s12_ctl_r <= s11_ctl_r;
      s12_pos_r <= pos12;
      s12_vel_r <= vel12;
      s12_acc_r <= sat_s32(a12);
    end
  end

  assign out_vld = v_r[NS-1] & ~s12_ctl_r.rb;
  assign out_pos = s12_pos_r;
  assign out_vel = s12_vel_r;

  assign wb.vld = v_r[NS-1] & s12_ctl_r.rb;
  assign wb.seg = s12_ctl_r.seg;
  assign wb.pos = s12_pos_r;
  assign wb.vel = s12_vel_r;
  assign wb.acc = s12_acc_r;

endmodule

// File: design/s_curve_profile_evaluator.sv
// ----------------------------------------------------------------------------
// s_curve_profile_evaluator: seven-segment jerk-limited S-curve evaluator
// Holds the profile registers and switch-point table; answers position and
// velocity queries through a twelve-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_index/cfg_wdata write one of six registers (jerk, accel and
//   velocity limits, jerk/accel/cruise durations); indexes 6 and 7 are
//   ignored. Each write rebuilds the 8-entry switch-point table by sending
//   segments 1..7 one at a time through the pipeline; in_ready is low
//   meanwhile. A new write restarts it.
//   in_valid/in_ready carry one query item (Q16.16 seconds); each item gives
//   one result item on out_valid/out_ready (position, velocity, saturated).
//   Throughput is one item per cycle while no rebuild runs and the receiver
//   keeps up. Results come from stage 12, the output register.
//   When the receiver stalls, the output register holds and earlier stages
//   keep filling until the pipeline is full; only then does in_ready drop.
//   Reset (rst_n low, synchronous) clears registers, table and pipeline;
//   the table of an all-zero configuration is all zero, so no rebuild runs.
// ----------------------------------------------------------------------------
module s_curve_profile_evaluator import sce_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DATA_W-1:0]    in_query_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    out_position,
  output logic [DATA_W-1:0]    out_velocity,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  // profile registers
  logic [DATA_W-1:0] jerk_r, accel_r, vel_r, jdur_r, adur_r, cdur_r;
  logic              cfg_hit;

  assign cfg_hit = cfg_we & (cfg_index <= REG_CDUR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jerk_r  <= '0;
      accel_r <= '0;
      vel_r   <= '0;
      jdur_r  <= '0;
      adur_r  <= '0;
      cdur_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_JERK:  jerk_r  <= cfg_wdata;
        REG_ACCEL: accel_r <= cfg_wdata;
        REG_VEL:   vel_r   <= cfg_wdata;
        REG_JDUR:  jdur_r  <= cfg_wdata;
        REG_ADUR:  adur_r  <= cfg_wdata;
        REG_CDUR:  cdur_r  <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // rebuild sequencer: one segment in flight at a time
  logic                busy_r, wait_r;
  logic [PT_IDX_W-1:0] seg_r;
  logic                pipe_rdy, issue, in_fire;
  wb_t                 wb;
  point_t              tbl_r [NUM_POINTS];
  logic [DATA_W-1:0]   dur;
  logic [DATA_W:0]     tsum;
  ctl_t                pin_ctl;

  always_comb begin
    unique case (seg_r)
      SEG_ACCEL, SEG_DECEL: dur = adur_r;
      SEG_CRUISE:           dur = cdur_r;
      default:              dur = jdur_r;
    endcase
    tsum = {1'b0, tbl_r[seg_r - 1'b1].tm} + {1'b0, dur};
  end

  assign in_ready = pipe_rdy & ~busy_r;
  assign in_fire  = in_valid & in_ready;
  assign issue    = busy_r & ~wait_r & ~cfg_hit & pipe_rdy;

  always_comb begin
    pin_ctl.rb   = issue;
    pin_ctl.pass = 1'b0;
    pin_ctl.seg  = issue ? seg_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      wait_r <= 1'b0;
      seg_r  <= SEG_JERK_IN;
    end else if (cfg_hit) begin
      busy_r <= 1'b1;
      wait_r <= 1'b0;
      seg_r  <= SEG_JERK_IN;
    end else begin
      if (issue) wait_r <= 1'b1;
      if (wb.vld) begin
        wait_r <= 1'b0;
        if (seg_r == SEG_DECEL_OUT) busy_r <= 1'b0;
        else seg_r <= seg_r + 1'b1;
      end
    end
  end

  // switch-point table; point 0 stays at zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POINTS; i++) tbl_r[i] <= '0;
    end else begin
      if (issue) tbl_r[seg_r].tm <= tsum[DATA_W] ? '1 : tsum[DATA_W-1:0];
      if (wb.vld && !cfg_hit) begin
        tbl_r[wb.seg].pos <= wb.pos;
        tbl_r[wb.seg].vel <= wb.vel;
        tbl_r[wb.seg].acc <= wb.acc;
      end
    end
  end

  sce_pipe #(
    .FRAC_BITS(FRAC_BITS)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (cfg_hit),
    .in_vld    (in_fire | issue),
    .in_rdy    (pipe_rdy),
    .in_ctl    (pin_ctl),
    .in_val    (issue ? dur : in_query_time),
    .tbl       (tbl_r),
    .jerk_lim  (jerk_r),
    .accel_lim (accel_r),
    .vel_lim   (vel_r),
    .out_vld   (out_valid),
    .out_rdy   (out_ready),
    .out_pos   (out_position),
    .out_vel   (out_velocity),
    .wb        (wb)
  );

endmodule

// File: test/s_curve_profile_evaluator_tb.sv
// ----------------------------------------------------------------------------
// s_curve_profile_evaluator_tb: self-checking bench for the S-curve evaluator
// Programs the profile registers, sends query-time items under random
// stalls on both sides, and checks position and velocity of every result
// item against an in-bench fixed-point model of the switch-point table and
// the per-segment cubic evaluation.
// ----------------------------------------------------------------------------
module s_curve_profile_evaluator_tb import sce_pkg::*;;

  localparam int           FRAC      = 16;
  localparam longint       W_LIM     = 64'sh2000_0000_0000_0000;
  localparam longint       U32_TOP   = 64'sh0000_0000_FFFF_FFFF;
  localparam int           WD_LIMIT  = 4000;  // cycles without any handshake
  localparam int           HOLD_LEN  = 400;   // long receiver hold-off
  localparam int           DRAIN_GAP = 20;    // > pipeline latency + margin

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [DATA_W-1:0]    in_query_time;
  logic                 out_valid;
  logic                 out_ready;
  logic [DATA_W-1:0]    out_position;
  logic [DATA_W-1:0]    out_velocity;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_wdata;

  s_curve_profile_evaluator i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_query_time (in_query_time),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_position  (out_position),
    .out_velocity  (out_velocity),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Profile model: register copies and the 8-entry switch-point table
  // --------------------------------------------------------------------------
  bit [31:0] jerk_lim, acc_lim, vel_lim, jerk_dur, acc_dur, cruise_dur;
  bit [31:0] pt_tm  [NUM_POINTS];
  bit [31:0] pt_pos [NUM_POINTS];
  bit [31:0] pt_vel [NUM_POINTS];
  int        pt_acc [NUM_POINTS];

  // expected results, oldest first
  bit [31:0] exp_pos_q[$];
  bit [31:0] exp_vel_q[$];

  int  err_cnt;
  bit  steady;     // sender: no gaps
  bit  rx_steady;  // receiver: no stalls
  bit  hold_req;   // receiver: one long hold-off
  int  wd_cnt;

  function automatic longint clamp_w(longint x);
    if (x > W_LIM) return W_LIM;
    if (x < -W_LIM) return -W_LIM;
    return x;
  endfunction

  function automatic longint add_w(longint a, longint b);
    return clamp_w(clamp_w(a) + clamp_w(b));
  endfunction

  function automatic longint sat_rng(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // Q product: exact magnitude product, truncated shift, saturated at 2^61
  function automatic longint fx_mul(longint a, longint b);
    bit         neg;
    bit [127:0] ma, mb, pr;
    longint     r;
    neg = (a < 0) != (b < 0);
    a   = clamp_w(a);
    b   = clamp_w(b);
    ma  = (a < 0) ? 128'(-a) : 128'(a);
    mb  = (b < 0) ? 128'(-b) : 128'(b);
    pr  = (ma * mb) >> FRAC;
    if (pr > 128'(W_LIM)) pr = 128'(W_LIM);
    r = longint'(pr[63:0]);
    return neg ? -r : r;
  endfunction

  // kinematics dt into segment seg, starting from point seg-1
  function automatic void seg_kin(int seg, longint dt, output longint a,
                                  output longint v, output longint p);
    int     b;
    longint a0, v0, p0, j, t2, t3;
    b  = seg - 1;
    a0 = longint'(pt_acc[b]);
    v0 = longint'(pt_vel[b]);
    p0 = longint'(pt_pos[b]);
    if (seg == SEG_JERK_IN || seg == SEG_DECEL_OUT) j = longint'(jerk_lim);
    else if (seg == SEG_JERK_OUT || seg == SEG_DECEL_IN) j = -longint'(jerk_lim);
    else j = 0;
    t2 = fx_mul(dt, dt);
    t3 = fx_mul(t2, dt);
    if (seg == SEG_ACCEL) a = longint'(acc_lim);
    else if (seg == SEG_DECEL) a = -longint'(acc_lim);
    else if (seg == SEG_CRUISE) a = 0;
    else a = add_w(a0, fx_mul(j, dt));
    if (seg == SEG_CRUISE) v = longint'(vel_lim);
    else v = add_w(add_w(v0, fx_mul(a0, dt)), fx_mul(j, t2) / 2);
    p = add_w(add_w(p0, fx_mul(v0, dt)), add_w(fx_mul(a0, t2) / 2, fx_mul(j, t3) / 6));
  endfunction

  function automatic void build_points();
    longint dt, a, v, p;
    pt_tm[0]  = '0;
    pt_pos[0] = '0;
    pt_vel[0] = '0;
    pt_acc[0] = 0;
    for (int i = 1; i < NUM_POINTS; i++) begin
      if (i == SEG_ACCEL || i == SEG_DECEL) dt = longint'(acc_dur);
      else if (i == SEG_CRUISE) dt = longint'(cruise_dur);
      else dt = longint'(jerk_dur);
      seg_kin(i, dt, a, v, p);
      pt_acc[i] = int'(sat_rng(a, -64'sd2147483648, 64'sd2147483647));
      pt_vel[i] = 32'(sat_rng(v, 0, U32_TOP));
      pt_pos[i] = 32'(sat_rng(p, 0, U32_TOP));
      pt_tm[i]  = 32'(sat_rng(longint'(pt_tm[i-1]) + dt, 0, U32_TOP));
    end
  endfunction

  function automatic void apply_reg(bit [CFG_IDX_W-1:0] idx, bit [31:0] val);
    case (idx)
      REG_JERK:  jerk_lim   = val;
      REG_ACCEL: acc_lim    = val;
      REG_VEL:   vel_lim    = val;
      REG_JDUR:  jerk_dur   = val;
      REG_ADUR:  acc_dur    = val;
      REG_CDUR:  cruise_dur = val;
      default:   return;      // indexes past the last register do nothing
    endcase
    build_points();
  endfunction

  function automatic void eval_query(bit [31:0] q, output bit [31:0] pos,
                                     output bit [31:0] vel);
    longint a, v, p;
    if (q <= pt_tm[0]) begin
      p = pt_pos[0];
      v = pt_vel[0];
    end else if (q > pt_tm[NUM_POINTS-1]) begin
      p = pt_pos[NUM_POINTS-1];
      v = pt_vel[NUM_POINTS-1];
    end else begin
      p = 0;
      v = 0;
      // first segment holding q; empty segments fall through
      for (int i = 1; i < NUM_POINTS; i++) begin
        if (pt_tm[i-1] < q && q <= pt_tm[i]) begin
          seg_kin(i, longint'(q - pt_tm[i-1]), a, v, p);
          break;
        end
      end
    end
    pos = 32'(sat_rng(p, 0, U32_TOP));
    vel = 32'(sat_rng(v, 0, U32_TOP));
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // one query item; valid held until accepted, expectation queued on accept
  task automatic send_query(bit [31:0] q);
    int        gap;
    bit [31:0] ep, ev;
    gap = steady ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_query_time <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    eval_query(q, ep, ev);
    exp_pos_q = {exp_pos_q, ep};
    exp_vel_q = {exp_vel_q, ev};
  endtask

  // stop sending, wait for every result plus pipeline latency
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (exp_pos_q.size() == 0);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // register write; only called with no query in flight (a rebuild may run)
  task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    apply_reg(idx, val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_profile(bit [31:0] j, bit [31:0] a, bit [31:0] v,
                               bit [31:0] jd, bit [31:0] ad, bit [31:0] cd);
    drain();
    write_reg(REG_JERK, j);
    write_reg(REG_ACCEL, a);
    write_reg(REG_VEL, v);
    write_reg(REG_JDUR, jd);
    write_reg(REG_ADUR, ad);
    write_reg(REG_CDUR, cd);
  endtask

  // each switch point and the time just before it, both ends, and just past the last point
  task automatic probe_points();
    send_query(32'h0);
    for (int i = 1; i < NUM_POINTS; i++) begin
      send_query(pt_tm[i] - 32'd1);
      send_query(pt_tm[i]);
    end
    send_query(pt_tm[NUM_POINTS-1] + 32'd1);
    send_query(32'hFFFF_FFFF);
  endtask

  function automatic bit [31:0] pick_query();
    int        r;
    bit [31:0] t;
    r = $urandom_range(0, 9);
    t = pt_tm[NUM_POINTS-1];
    if (r < 6) return $urandom_range(0, t);
    if (r < 8) return pt_tm[$urandom_range(0, NUM_POINTS-1)] + $urandom_range(0, 2) - 1;
    return $urandom;
  endfunction

  function automatic bit [31:0] pick_reg(bit is_dur);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return is_dur ? $urandom_range(0, 32'h4_0000) : $urandom_range(0, 32'h8_0000);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stall per item, optional long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int n;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 1'b0;
      end
      n = rx_steady ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Result check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (exp_pos_q.size() == 0) begin
        $error("unexpected result item: position %h velocity %h", out_position,
               out_velocity);
        err_cnt++;
      end else begin
        if (out_position !== exp_pos_q[0]) begin
          $error("position: expected %h, got %h", exp_pos_q[0], out_position);
          err_cnt++;
        end
        if (out_velocity !== exp_vel_q[0]) begin
          $error("velocity: expected %h, got %h", exp_vel_q[0], out_velocity);
          err_cnt++;
        end
        void'(exp_pos_q.pop_front());
        void'(exp_vel_q.pop_front());
      end
    end
  end

  // watchdog: cycles with work pending but no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && exp_pos_q.size() == 0)) begin
      wd_cnt <= 0;
    end else if (wd_cnt >= WD_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      wd_cnt <= wd_cnt + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // zero registers after reset: flat all-zero table
  task automatic test_reset_state();
    send_query(32'h0);
    send_query(32'h1);
    send_query(32'h8000_0000);
    send_query(32'hFFFF_FFFF);
  endtask

  // consistent 1 s jerk / 1 s accel / 2 s cruise profile
  task automatic test_nominal();
    write_profile(32'h1_0000, 32'h1_0000, 32'h2_0000, 32'h1_0000, 32'h1_0000, 32'h2_0000);
    probe_points();
  endtask

  // empty accel and cruise segments get skipped; bogus indexes ignored
  task automatic test_empty_segments();
    write_profile(32'h2_0000, 32'h3_0000, 32'h1_8000, 32'h8000, 32'h0, 32'h0);
    write_reg(3'd6, 32'hDEAD_BEEF);
    write_reg(3'd7, 32'h1234_5678);
    probe_points();
  endtask

  // all-ones registers: time saturation and value clamps
  task automatic test_extremes();
    write_profile('1, '1, '1, '1, '1, '1);
    probe_points();
    // limits that do not fit: negative velocity clamps to zero
    write_profile(32'h10_0000, 32'h0, 32'h0, 32'h2_0000, 32'h1_0000, 32'h1_0000);
    probe_points();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      write_reg(REG_JERK, pick_reg(0));
      write_reg(REG_ACCEL, pick_reg(0));
      write_reg(REG_VEL, pick_reg(0));
      write_reg(REG_JDUR, pick_reg(1));
      write_reg(REG_ADUR, pick_reg(1));
      write_reg(REG_CDUR, pick_reg(1));
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'(6 + $urandom_range(0, 1)), $urandom);
      steady    = (ph % 4 == 1);
      rx_steady = (ph % 4 == 2);
      if (ph == 3) hold_req = 1'b1;  // block fills and stalls its input
      for (int k = 0; k < 53; k++) begin
        send_query(pick_query());
        if (ph == 5 && k == 30) drain();  // sender waits for all results
      end
    end
    steady    = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_query_time = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    err_cnt       = 0;
    steady        = 1'b0;
    rx_steady     = 1'b0;
    hold_req      = 1'b0;
    jerk_lim      = '0;
    acc_lim       = '0;
    vel_lim       = '0;
    jerk_dur      = '0;
    acc_dur       = '0;
    cruise_dur    = '0;
    build_points();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_nominal();
    test_empty_segments();
    test_extremes();
    test_random();
    drain();

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
